// ===== rtl/tsr_pkg.sv =====
// Shared types, constants and helper functions for the torus source route generator.
// No dependencies; every other file of the block imports this package.
package tsr_pkg;

   // Fixed field widths
   localparam int NODE_W      = 12;  // linear node number
   localparam int SIDE_W      = 5;   // grid side register
   localparam int PLANE_W     = 9;   // width * height, up to 256
   localparam int TOTAL_W     = 13;  // width * height * depth, up to 4096
   localparam int COORD_MAX_W = 4;   // widest coordinate or hop count on one axis
   localparam int PORT_W      = 3;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_GRID_DEPTH  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_WRAP_X      = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_WRAP_Y      = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_WRAP_Z      = 3'd5;

   localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd4;

   // Exit ports
   localparam logic [PORT_W-1:0] PORT_EAST  = 3'd0;
   localparam logic [PORT_W-1:0] PORT_SOUTH = 3'd1;
   localparam logic [PORT_W-1:0] PORT_WEST  = 3'd2;
   localparam logic [PORT_W-1:0] PORT_NORTH = 3'd3;
   localparam logic [PORT_W-1:0] PORT_BACK  = 3'd4;
   localparam logic [PORT_W-1:0] PORT_FRONT = 3'd5;

   typedef struct packed {
      logic [SIDE_W-1:0] grid_width;
      logic [SIDE_W-1:0] grid_height;
      logic [SIDE_W-1:0] grid_depth;
      logic              wrap_x;
      logic              wrap_y;
      logic              wrap_z;
   } cfg_type;

   // Hops along one axis: count and direction (neg set for the minus way)
   typedef struct packed {
      logic                   neg;
      logic [COORD_MAX_W-1:0] cnt;
   } axis_move_type;

   // One classified route handed from front to back
   typedef struct packed {
      logic          oog;
      logic          empty;
      axis_move_type mx;
      axis_move_type my;
      axis_move_type mz;
   } route_cmd_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_MUL1,
      FR_MUL2,
      FR_CHECK,
      FR_DIVZ,
      FR_DIVY,
      FR_DELTA,
      FR_PUSH
   } front_state_type;

   // Shortest way along one axis; on a ring a tie goes the minus way
   function automatic axis_move_type axis_delta(input logic [COORD_MAX_W-1:0] a,
                                                input logic [COORD_MAX_W-1:0] b,
                                                input logic [SIDE_W-1:0]      n,
                                                input logic                   ring);
      axis_move_type mv;
      logic [SIDE_W:0] ea;
      logic [SIDE_W:0] eb;
      logic [SIDE_W:0] en;
      logic [SIDE_W:0] ng;
      logic [SIDE_W:0] ps;
      ea = (SIDE_W+1)'(a);
      eb = (SIDE_W+1)'(b);
      en = (SIDE_W+1)'(n);
      if (ea > eb) begin
         ng = ea - eb;
         ps = eb + en - ea;
      end else begin
         ng = ea + en - eb;
         ps = eb - ea;
      end
      if (!ring) begin
         if (eb >= ea) begin
            mv.neg = 1'b0;
            mv.cnt = ps[COORD_MAX_W-1:0];
         end else begin
            mv.neg = 1'b1;
            mv.cnt = ng[COORD_MAX_W-1:0];
         end
      end else if (ng > ps) begin
         mv.neg = 1'b0;
         mv.cnt = ps[COORD_MAX_W-1:0];
      end else begin
         mv.neg = 1'b1;
         mv.cnt = ng[COORD_MAX_W-1:0];
      end
      return mv;
   endfunction

endpackage

// ===== rtl/tsr_front.sv =====
// Front end: accepts a node pair, checks it against the grid, splits it into
// coordinates with a shared restoring divider and queues a route command. Uses tsr_pkg.
module tsr_front import tsr_pkg::*; #(
   parameter int MAX_SIDE = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_push,
   output logic                req_full,
   input  logic [NODE_W-1:0]   req_source_node,
   input  logic [NODE_W-1:0]   req_target_node,
   output logic                q_push,
   output route_cmd_type       q_data,
   input  logic                q_full
);

   localparam int COORD_W = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
   localparam int STEP_W  = (COORD_W > 1) ? $clog2(COORD_W) : 1;
   localparam logic [SIDE_W-1:0] MAX_SIDE_C = SIDE_W'(MAX_SIDE);
   localparam logic [STEP_W-1:0] STEP_TOP   = STEP_W'(COORD_W - 1);

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
      logic [SIDE_W-1:0] r;
      if (s == '0) begin
         r = SIDE_W'(1);
      end else if (s > MAX_SIDE_C) begin
         r = MAX_SIDE_C;
      end else begin
         r = s;
      end
      return r;
   endfunction

   front_state_type     state_ff, state_in;
   logic [NODE_W-1:0]   src_ff, src_in, dst_ff, dst_in;
   logic [SIDE_W-1:0]   w_ff, w_in, h_ff, h_in, d_ff, d_in;
   logic [2:0]          wrap_ff, wrap_in;
   logic [PLANE_W-1:0]  plane_ff, plane_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [PLANE_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [NODE_W-1:0]   src_rem_ff, src_rem_in, dst_rem_ff, dst_rem_in;
   logic [COORD_W-1:0]  src_z_ff, src_z_in, dst_z_ff, dst_z_in;
   logic [COORD_W-1:0]  src_y_ff, src_y_in, dst_y_ff, dst_y_in;
   route_cmd_type       cmd_ff, cmd_in;

   logic                oog_now;
   logic [TOTAL_W-1:0]  div_shift;
   logic                src_ge, dst_ge;
   axis_move_type       mv_x, mv_y, mv_z;

   assign oog_now   = (TOTAL_W'(src_ff) >= total_ff) || (TOTAL_W'(dst_ff) >= total_ff);
   assign div_shift = TOTAL_W'(div_ff) << step_ff;
   assign src_ge    = TOTAL_W'(src_rem_ff) >= div_shift;
   assign dst_ge    = TOTAL_W'(dst_rem_ff) >= div_shift;

   assign mv_x = axis_delta(COORD_MAX_W'(src_rem_ff[COORD_W-1:0]),
                            COORD_MAX_W'(dst_rem_ff[COORD_W-1:0]), w_ff, wrap_ff[0]);
   assign mv_y = axis_delta(COORD_MAX_W'(src_y_ff), COORD_MAX_W'(dst_y_ff), h_ff, wrap_ff[1]);
   assign mv_z = axis_delta(COORD_MAX_W'(src_z_ff), COORD_MAX_W'(dst_z_ff), d_ff, wrap_ff[2]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE:  if (req_push) state_in = FR_MUL1;
         FR_MUL1:  state_in = FR_MUL2;
         FR_MUL2:  state_in = FR_CHECK;
         FR_CHECK: state_in = oog_now ? FR_PUSH : FR_DIVZ;
         FR_DIVZ:  if (step_ff == '0) state_in = FR_DIVY;
         FR_DIVY:  if (step_ff == '0) state_in = FR_DELTA;
         FR_DELTA: state_in = FR_PUSH;
         FR_PUSH:  if (!q_full) state_in = FR_IDLE;
         default:  state_in = FR_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_full = (state_ff != FR_IDLE);
      q_push   = (state_ff == FR_PUSH) && !q_full;
      q_data   = cmd_ff;
   end

   // datapath
   always_comb begin
      src_in     = src_ff;
      dst_in     = dst_ff;
      w_in       = w_ff;
      h_in       = h_ff;
      d_in       = d_ff;
      wrap_in    = wrap_ff;
      plane_in   = plane_ff;
      total_in   = total_ff;
      div_in     = div_ff;
      step_in    = step_ff;
      src_rem_in = src_rem_ff;
      dst_rem_in = dst_rem_ff;
      src_z_in   = src_z_ff;
      dst_z_in   = dst_z_ff;
      src_y_in   = src_y_ff;
      dst_y_in   = dst_y_ff;
      cmd_in     = cmd_ff;
      case (state_ff)
         FR_IDLE: begin
            if (req_push) begin
               src_in  = req_source_node;
               dst_in  = req_target_node;
               w_in    = clamp_side(cfg.grid_width);
               h_in    = clamp_side(cfg.grid_height);
               d_in    = clamp_side(cfg.grid_depth);
               wrap_in = {cfg.wrap_z, cfg.wrap_y, cfg.wrap_x};
            end
         end
         FR_MUL1: plane_in = PLANE_W'(w_ff) * PLANE_W'(h_ff);
         FR_MUL2: total_in = TOTAL_W'(plane_ff) * TOTAL_W'(d_ff);
         FR_CHECK: begin
            src_rem_in = src_ff;
            dst_rem_in = dst_ff;
            div_in     = plane_ff;
            step_in    = STEP_TOP;
            cmd_in     = '0;
            cmd_in.oog = oog_now;
         end
         FR_DIVZ, FR_DIVY: begin
            // one quotient bit per cycle for both nodes
            if (src_ge) src_rem_in = NODE_W'(TOTAL_W'(src_rem_ff) - div_shift);
            if (dst_ge) dst_rem_in = NODE_W'(TOTAL_W'(dst_rem_ff) - div_shift);
            if (state_ff == FR_DIVZ) begin
               src_z_in[step_ff] = src_ge;
               dst_z_in[step_ff] = dst_ge;
            end else begin
               src_y_in[step_ff] = src_ge;
               dst_y_in[step_ff] = dst_ge;
            end
            if (step_ff == '0) begin
               div_in  = PLANE_W'(w_ff);
               step_in = STEP_TOP;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         FR_DELTA: begin
            cmd_in.oog   = 1'b0;
            cmd_in.mx    = mv_x;
            cmd_in.my    = mv_y;
            cmd_in.mz    = mv_z;
            cmd_in.empty = (mv_x.cnt == '0) && (mv_y.cnt == '0) && (mv_z.cnt == '0);
         end
         FR_PUSH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      src_ff     <= src_in;
      dst_ff     <= dst_in;
      w_ff       <= w_in;
      h_ff       <= h_in;
      d_ff       <= d_in;
      wrap_ff    <= wrap_in;
      plane_ff   <= plane_in;
      total_ff   <= total_in;
      div_ff     <= div_in;
      step_ff    <= step_in;
      src_rem_ff <= src_rem_in;
      dst_rem_ff <= dst_rem_in;
      src_z_ff   <= src_z_in;
      dst_z_ff   <= dst_z_in;
      src_y_ff   <= src_y_in;
      dst_y_ff   <= dst_y_in;
      cmd_ff     <= cmd_in;
   end

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FR_DIVZ || state_ff == FR_DIVY) |-> (div_ff != '0))
      else $error("divider runs with a zero divisor");

   a_x_below_width: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FR_DELTA) |->
         (TOTAL_W'(src_rem_ff) < TOTAL_W'(w_ff)) && (TOTAL_W'(dst_rem_ff) < TOTAL_W'(w_ff)))
      else $error("x remainder not below grid width");

   a_cmd_class: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !(q_data.oog && q_data.empty))
      else $error("route command both out of grid and empty");

endmodule

// ===== rtl/tsr_queue.sv =====
// Short command queue between front and back end, held in flip-flops.
// Uses tsr_pkg for the command type.
module tsr_queue import tsr_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  route_cmd_type data_in,
   output logic          full,
   input  logic          pop,
   output logic          valid,
   output route_cmd_type data_out
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   route_cmd_type      mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign valid    = (count_ff != '0);
   assign data_out = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) mem_ff[wr_ptr_ff] <= data_in;
   end

endmodule

// ===== rtl/tsr_back.sv =====
// Back end: takes route commands from the queue and, while the output register is free,
// issues one hop per cycle into it, X hops first, then Y, then Z. Uses tsr_pkg.
module tsr_back import tsr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  route_cmd_type       q_data,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [PORT_W-1:0]   rsp_hop_port,
   output logic                rsp_last_hop,
   output logic                rsp_route_empty,
   output logic                rsp_node_out_of_grid
);

   logic                busy_ff, busy_in;
   route_cmd_type       cur_ff, cur_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PORT_W-1:0]   port_ff, port_in;
   logic                last_ff, last_in;
   logic                empty_ff, empty_in;
   logic                oog_ff, oog_in;

   logic                out_free, fire;
   route_cmd_type       nxt;
   logic [PORT_W-1:0]   hop_port;
   logic                hop_last;

   assign out_free = !rsp_valid_ff || rsp_pop;
   assign fire     = busy_ff && out_free;
   assign q_pop    = !busy_ff && q_valid;

   // pick the next hop and retire it from the command
   always_comb begin
      nxt      = cur_ff;
      hop_port = PORT_EAST;
      if (cur_ff.oog || cur_ff.empty) begin
         hop_port = PORT_EAST;
      end else if (cur_ff.mx.cnt != '0) begin
         hop_port    = cur_ff.mx.neg ? PORT_WEST : PORT_EAST;
         nxt.mx.cnt  = cur_ff.mx.cnt - COORD_MAX_W'(1);
      end else if (cur_ff.my.cnt != '0) begin
         hop_port    = cur_ff.my.neg ? PORT_NORTH : PORT_SOUTH;
         nxt.my.cnt  = cur_ff.my.cnt - COORD_MAX_W'(1);
      end else begin
         hop_port    = cur_ff.mz.neg ? PORT_FRONT : PORT_BACK;
         nxt.mz.cnt  = cur_ff.mz.cnt - COORD_MAX_W'(1);
      end
      hop_last = cur_ff.oog || cur_ff.empty ||
                 ((nxt.mx.cnt == '0) && (nxt.my.cnt == '0) && (nxt.mz.cnt == '0));
   end

   always_comb begin
      busy_in      = busy_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff;
      port_in      = port_ff;
      last_in      = last_ff;
      empty_in     = empty_ff;
      oog_in       = oog_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         cur_in  = q_data;
      end else if (fire) begin
         cur_in = nxt;
         if (hop_last) busy_in = 1'b0;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
         port_in      = hop_port;
         last_in      = hop_last;
         empty_in     = cur_ff.empty;
         oog_in       = cur_ff.oog;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff   <= cur_in;
      port_ff  <= port_in;
      last_ff  <= last_in;
      empty_ff <= empty_in;
      oog_ff   <= oog_in;
   end

   assign rsp_empty            = !rsp_valid_ff;
   assign rsp_hop_port         = port_ff;
   assign rsp_last_hop         = last_ff;
   assign rsp_route_empty      = empty_ff;
   assign rsp_node_out_of_grid = oog_ff;

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(empty_ff && oog_ff))
      else $error("result flagged both empty and out of grid");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (empty_ff || oog_ff)) |-> last_ff)
      else $error("special result not marked last");

   a_busy_has_hops: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !cur_ff.oog && !cur_ff.empty) |->
         ((cur_ff.mx.cnt != '0) || (cur_ff.my.cnt != '0) || (cur_ff.mz.cnt != '0)))
      else $error("active route has no hops left");

endmodule

// ===== rtl/torus_source_route_generator.sv =====
// Top level of the torus source route generator: configuration registers,
// front end, command queue and back end. Uses tsr_pkg, tsr_front, tsr_queue, tsr_back.
//
//   channel  | ports                         | transaction
//   ---------+-------------------------------+-------------------------------------------
//   request  | req_push / req_full           | one source and target node pair
//   response | rsp_pop / rsp_empty           | one hop port with last, empty, oog flags
//   csr      | csr_psel/penable/pwrite/...   | one register write or read, no wait states
//
// Steps: the front end takes each request through the multiply states MUL1 and MUL2, a
// range check, one quotient bit per cycle for Z then Y, a delta state and a queue push
// (an off-grid pair goes from the check straight to the push); the back end loads each
// command from the queue, then issues one result per cycle while its output is free.
// The front end accepts the next request while the back end still drains earlier routes.
// Reset clears the state machines, the queue and the output valid, and loads the
// register reset values (4 x 4 x 4 grid, all axes wrapped). No clearing pass.
// A stalled response holds its output register; the back end stops, the queue fills,
// and then req_full stays high.
module torus_source_route_generator import tsr_pkg::*; #(
   parameter int MAX_SIDE    = 16,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [NODE_W-1:0]       req_source_node,
   input  logic [NODE_W-1:0]       req_target_node,
   // response channel
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [PORT_W-1:0]       rsp_hop_port,
   output logic                    rsp_last_hop,
   output logic                    rsp_route_empty,
   output logic                    rsp_node_out_of_grid,
   // configuration port
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   cfg_type              cfg_ff, cfg_in;
   logic                 csr_write;
   logic [REG_IDX_W-1:0] csr_idx;

   logic                 q_push, q_full, q_pop, q_valid;
   route_cmd_type        q_wdata, q_rdata;

   // Registers sit at word addresses; ignore the byte offset.
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes; an address past the last register is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_idx)
            REG_GRID_WIDTH:  cfg_in.grid_width  = csr_pwdata[SIDE_W-1:0];
            REG_GRID_HEIGHT: cfg_in.grid_height = csr_pwdata[SIDE_W-1:0];
            REG_GRID_DEPTH:  cfg_in.grid_depth  = csr_pwdata[SIDE_W-1:0];
            REG_WRAP_X:      cfg_in.wrap_x      = csr_pwdata[0];
            REG_WRAP_Y:      cfg_in.wrap_y      = csr_pwdata[0];
            REG_WRAP_Z:      cfg_in.wrap_z      = csr_pwdata[0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   // Register reads return the stored value, zero past the last register.
   always_comb begin
      case (csr_idx)
         REG_GRID_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.grid_width);
         REG_GRID_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.grid_height);
         REG_GRID_DEPTH:  csr_prdata = CSR_DATA_W'(cfg_ff.grid_depth);
         REG_WRAP_X:      csr_prdata = CSR_DATA_W'(cfg_ff.wrap_x);
         REG_WRAP_Y:      csr_prdata = CSR_DATA_W'(cfg_ff.wrap_y);
         REG_WRAP_Z:      csr_prdata = CSR_DATA_W'(cfg_ff.wrap_z);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width  <= SIDE_RESET;
         cfg_ff.grid_height <= SIDE_RESET;
         cfg_ff.grid_depth  <= SIDE_RESET;
         cfg_ff.wrap_x      <= 1'b1;
         cfg_ff.wrap_y      <= 1'b1;
         cfg_ff.wrap_z      <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: classify the request, split nodes into coordinates, build the command.
   tsr_front #(
      .MAX_SIDE (MAX_SIDE)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_source_node (req_source_node),
      .req_target_node (req_target_node),
      .q_push          (q_push),
      .q_data          (q_wdata),
      .q_full          (q_full)
   );

   // Decouple the two halves so each can stall on its own.
   tsr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .data_in  (q_wdata),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .data_out (q_rdata)
   );

   // Back end: walk the command and issue one hop per response transaction.
   tsr_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_data               (q_rdata),
      .q_pop                (q_pop),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_hop_port         (rsp_hop_port),
      .rsp_last_hop         (rsp_last_hop),
      .rsp_route_empty      (rsp_route_empty),
      .rsp_node_out_of_grid (rsp_node_out_of_grid)
   );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for torus_source_route_generator: directed routes, then random
// routes over many grid shapes, checked hop by hop against a route predictor.
// Depends on tsr_pkg and the RTL of the block only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tsr_pkg::*;

   localparam int MAX_SIDE       = 16;
   localparam int IDLE_PCT       = 38;    // chance of an idle cycle on either side
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off that fills the block
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
   localparam int DRAIN_CYCLES   = 100;   // quiet time at the end for stray hops
   localparam int MAX_REPORTS    = 10;

   // One expected hop, laid out like the response ports
   typedef struct packed {
      logic [PORT_W-1:0] hop_port;
      logic              last_hop;
      logic              route_empty;
      logic              node_out_of_grid;
   } hop_type;

   // Directed row: a route and, where it is obvious, the single hop it must give
   typedef struct {
      logic [NODE_W-1:0] src;
      logic [NODE_W-1:0] dst;
      bit                typed;
      hop_type           want;
   } route_case_type;

   // One grid setting and the traffic run under it
   typedef struct {
      cfg_type grid;
      int      items;
      bit      steady;  // no idling on either side
      bit      hold;    // receiver holds off early in the phase
   } phase_type;

   localparam hop_type EMPTY_ROUTE = '{PORT_EAST, 1'b1, 1'b1, 1'b0};
   localparam hop_type OFF_GRID    = '{PORT_EAST, 1'b1, 1'b0, 1'b1};
   localparam hop_type PREDICTED   = '0;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic [NODE_W-1:0]     req_source_node;
   logic [NODE_W-1:0]     req_target_node;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic [PORT_W-1:0]     rsp_hop_port;
   logic                  rsp_last_hop;
   logic                  rsp_route_empty;
   logic                  rsp_node_out_of_grid;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cfg_type grid_cfg;             // predictor's copy of the registers
   hop_type pending_hops[$];      // hops still owed by the block, oldest first
   int      mismatch_count = 0;
   int      stuck_cycles = 0;
   bit      steady = 1'b0;
   bit      hold_rsp = 1'b0;

   // Reset config (4 x 4 x 4, all rings): origin, corners, off-grid nodes, one hop
   // each way on every axis, the short way around, ties, and mixed routes.
   route_case_type directed_cases [23] = '{
      '{12'd0,    12'd0,    1'b1, EMPTY_ROUTE},
      '{12'd63,   12'd63,   1'b1, EMPTY_ROUTE},
      '{12'd64,   12'd0,    1'b1, OFF_GRID},
      '{12'd0,    12'd64,   1'b1, OFF_GRID},
      '{12'd4095, 12'd4095, 1'b1, OFF_GRID},
      '{12'd4095, 12'd0,    1'b1, OFF_GRID},
      '{12'd0,    12'd4095, 1'b1, OFF_GRID},
      '{12'd0,    12'd1,    1'b1, '{PORT_EAST,  1'b1, 1'b0, 1'b0}},
      '{12'd1,    12'd0,    1'b1, '{PORT_WEST,  1'b1, 1'b0, 1'b0}},
      '{12'd0,    12'd4,    1'b1, '{PORT_SOUTH, 1'b1, 1'b0, 1'b0}},
      '{12'd4,    12'd0,    1'b1, '{PORT_NORTH, 1'b1, 1'b0, 1'b0}},
      '{12'd0,    12'd16,   1'b1, '{PORT_BACK,  1'b1, 1'b0, 1'b0}},
      '{12'd16,   12'd0,    1'b1, '{PORT_FRONT, 1'b1, 1'b0, 1'b0}},
      '{12'd0,    12'd3,    1'b1, '{PORT_WEST,  1'b1, 1'b0, 1'b0}},
      '{12'd3,    12'd0,    1'b1, '{PORT_EAST,  1'b1, 1'b0, 1'b0}},
      '{12'd0,    12'd48,   1'b1, '{PORT_FRONT, 1'b1, 1'b0, 1'b0}},
      '{12'd0,    12'd2,    1'b0, PREDICTED},
      '{12'd2,    12'd0,    1'b0, PREDICTED},
      '{12'd0,    12'd42,   1'b0, PREDICTED},
      '{12'd0,    12'd63,   1'b0, PREDICTED},
      '{12'd63,   12'd0,    1'b0, PREDICTED},
      '{12'd21,   12'd42,   1'b0, PREDICTED},
      '{12'd5,    12'd58,   1'b0, PREDICTED}
   };

   // Fixed grid settings: largest ring and mesh, the one-node grid, zero and
   // oversized sides (read as 1 and MAX_SIDE), odd shapes with mixed wrapping.
   phase_type fixed_phases [7] = '{
      '{'{5'd16, 5'd16, 5'd16, 1'b1, 1'b1, 1'b1}, 60, 1'b1, 1'b0},
      '{'{5'd16, 5'd16, 5'd16, 1'b0, 1'b0, 1'b0}, 60, 1'b0, 1'b1},
      '{'{5'd1,  5'd1,  5'd1,  1'b1, 1'b1, 1'b1}, 20, 1'b0, 1'b0},
      '{'{5'd0,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0}, 20, 1'b0, 1'b0},
      '{'{5'd31, 5'd17, 5'd20, 1'b1, 1'b0, 1'b1}, 50, 1'b0, 1'b0},
      '{'{5'd3,  5'd5,  5'd7,  1'b1, 1'b0, 1'b1}, 50, 1'b0, 1'b0},
      '{'{5'd16, 5'd1,  5'd2,  1'b0, 1'b1, 1'b1}, 40, 1'b0, 1'b0}
   };

   torus_source_route_generator #(
      .MAX_SIDE (MAX_SIDE)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_source_node      (req_source_node),
      .req_target_node      (req_target_node),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_hop_port         (rsp_hop_port),
      .rsp_last_hop         (rsp_last_hop),
      .rsp_route_empty      (rsp_route_empty),
      .rsp_node_out_of_grid (rsp_node_out_of_grid),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Route predictor
   // ---------------------------------------------------------------------------------

   // Side register as the block uses it: zero reads as one, large values saturate
   function automatic int eff_side(logic [SIDE_W-1:0] raw);
      if (raw == '0) return 1;
      if (int'(raw) > MAX_SIDE) return MAX_SIDE;
      return int'(raw);
   endfunction

   // Signed hop count along one axis, positive for the plus way. On a ring take the
   // shorter way around; an even split goes the minus way.
   function automatic int axis_hops(int from, int to, int side, logic ring);
      int down;
      int up;
      if (!ring) return to - from;
      if (from > to) begin
         down = from - to;
         up   = to + side - from;
      end else begin
         down = from + side - to;
         up   = to - from;
      end
      return (down > up) ? up : -down;
   endfunction

   function automatic void queue_axis(int steps, logic [PORT_W-1:0] plus_port,
                                      logic [PORT_W-1:0] minus_port);
      hop_type hop;
      int      left;
      hop  = '0;
      left = steps;
      while (left > 0) begin
         hop.hop_port = plus_port;
         pending_hops = {pending_hops, hop};
         left--;
      end
      while (left < 0) begin
         hop.hop_port = minus_port;
         pending_hops = {pending_hops, hop};
         left++;
      end
   endfunction

   // Append every hop that one accepted route must produce
   function automatic void predict_route(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
      int      w, h, d, plane, cells;
      int      s, t, dx, dy, dz;
      hop_type hop;
      w     = eff_side(grid_cfg.grid_width);
      h     = eff_side(grid_cfg.grid_height);
      d     = eff_side(grid_cfg.grid_depth);
      plane = w * h;
      cells = plane * d;
      s     = int'(src);
      t     = int'(dst);
      hop   = '0;
      hop.last_hop = 1'b1;
      // Either node off the grid: one flagged hop, nothing else
      if (s >= cells || t >= cells) begin
         hop.node_out_of_grid = 1'b1;
         pending_hops = {pending_hops, hop};
         return;
      end
      dx = axis_hops(s % w, t % w, w, grid_cfg.wrap_x);
      dy = axis_hops((s % plane) / w, (t % plane) / w, h, grid_cfg.wrap_y);
      dz = axis_hops(s / plane, t / plane, d, grid_cfg.wrap_z);
      // Same coordinates on every axis: one hop marked empty
      if (dx == 0 && dy == 0 && dz == 0) begin
         hop.route_empty = 1'b1;
         pending_hops = {pending_hops, hop};
         return;
      end
      // Dimension order: X, then Y, then Z; last flag on the final hop only
      queue_axis(dx, PORT_EAST, PORT_WEST);
      queue_axis(dy, PORT_SOUTH, PORT_NORTH);
      queue_axis(dz, PORT_BACK, PORT_FRONT);
      pending_hops[pending_hops.size() - 1].last_hop = 1'b1;
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------

   // Register write: setup cycle, then access cycle; the register takes the value at
   // the edge that ends the access. Junk above the register width must be dropped.
   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [SIDE_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = ($urandom() & ~32'h1f) | CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_GRID_WIDTH:  grid_cfg.grid_width  = value;
         REG_GRID_HEIGHT: grid_cfg.grid_height = value;
         REG_GRID_DEPTH:  grid_cfg.grid_depth  = value;
         REG_WRAP_X:      grid_cfg.wrap_x      = value[0];
         REG_WRAP_Y:      grid_cfg.wrap_y      = value[0];
         REG_WRAP_Z:      grid_cfg.wrap_z      = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Offer one route and hold it until the block takes it. Called and returns at a
   // falling edge; push stays high into the next call unless that call idles first.
   task automatic send_route(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst,
                             bit typed, hop_type want);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push        = 1'b1;
      req_source_node = src;
      req_target_node = dst;
      @(posedge clock);
      while (req_full) @(posedge clock);
      // Accepted at this edge: record what it owes
      if (typed) pending_hops = {pending_hops, want};
      else predict_route(src, dst);
      @(negedge clock);
   endtask

   // Route with mostly in-grid nodes, some repeats of the source, some raw 12-bit noise
   task automatic send_random_route(int cells);
      logic [NODE_W-1:0] src;
      logic [NODE_W-1:0] dst;
      int                pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         src = NODE_W'($urandom());
         dst = NODE_W'($urandom());
      end else begin
         src = NODE_W'($urandom_range(cells - 1));
         dst = (pick < 16) ? src : NODE_W'($urandom_range(cells - 1));
      end
      send_route(src, dst, 1'b0, PREDICTED);
   endtask

   // Drain, reprogram every register, then drive this phase's traffic
   task automatic run_phase(phase_type ph);
      int cells;
      req_push = 1'b0;
      while (pending_hops.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_write(REG_GRID_WIDTH,  ph.grid.grid_width);
      csr_write(REG_GRID_HEIGHT, ph.grid.grid_height);
      csr_write(REG_GRID_DEPTH,  ph.grid.grid_depth);
      csr_write(REG_WRAP_X,      SIDE_W'(ph.grid.wrap_x));
      csr_write(REG_WRAP_Y,      SIDE_W'(ph.grid.wrap_y));
      csr_write(REG_WRAP_Z,      SIDE_W'(ph.grid.wrap_z));
      steady = ph.steady;
      if (ph.hold) hold_rsp = 1'b1;
      cells = eff_side(grid_cfg.grid_width) * eff_side(grid_cfg.grid_height)
              * eff_side(grid_cfg.grid_depth);
      // Far corners both ways, then the last node against the top node number
      send_route(12'd0, NODE_W'(cells - 1), 1'b0, PREDICTED);
      send_route(NODE_W'(cells - 1), 12'd0, 1'b0, PREDICTED);
      send_route(NODE_W'(cells - 1), 12'd4095, 1'b0, PREDICTED);
      repeat (ph.items) send_random_route(cells);
      req_push = 1'b0;
      steady   = 1'b0;
   endtask

   initial begin
      phase_type rand_phase;
      reset           = 1'b1;
      req_push        = 1'b0;
      req_source_node = '0;
      req_target_node = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      grid_cfg        = '{SIDE_RESET, SIDE_RESET, SIDE_RESET, 1'b1, 1'b1, 1'b1};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table under the reset grid
      foreach (directed_cases[i])
         send_route(directed_cases[i].src, directed_cases[i].dst,
                    directed_cases[i].typed, directed_cases[i].want);
      req_push = 1'b0;

      foreach (fixed_phases[i]) run_phase(fixed_phases[i]);

      // A few random grid shapes to finish
      repeat (3) begin
         rand_phase.grid.grid_width  = SIDE_W'($urandom_range(1, MAX_SIDE));
         rand_phase.grid.grid_height = SIDE_W'($urandom_range(1, MAX_SIDE));
         rand_phase.grid.grid_depth  = SIDE_W'($urandom_range(1, MAX_SIDE));
         rand_phase.grid.wrap_x      = 1'($urandom_range(1));
         rand_phase.grid.wrap_y      = 1'($urandom_range(1));
         rand_phase.grid.wrap_z      = 1'($urandom_range(1));
         rand_phase.items            = 6;
         rand_phase.steady           = 1'b0;
         rand_phase.hold             = 1'b0;
         run_phase(rand_phase);
      end

      // Wait for every owed hop, then stay quiet long enough to catch strays
      while (pending_hops.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Receiver: random pops, no idling during steady stretches, one long hold-off on request
   // ---------------------------------------------------------------------------------
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            // Hold pop low while the sender keeps pushing so req_full must assert
            rsp_pop = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_pop = reset ? 1'b0 : (steady || $urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Checker: compare each popped hop with the oldest expectation
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      hop_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_hops.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("%0t: unexpected hop port=%0d last=%0b empty=%0b oog=%0b",
                        $realtime, rsp_hop_port, rsp_last_hop, rsp_route_empty,
                        rsp_node_out_of_grid);
            mismatch_count++;
         end else begin
            want = pending_hops.pop_front();
            if (rsp_hop_port !== want.hop_port || rsp_last_hop !== want.last_hop ||
                rsp_route_empty !== want.route_empty ||
                rsp_node_out_of_grid !== want.node_out_of_grid) begin
               if (mismatch_count < MAX_REPORTS)
                  $display({"%0t: hop mismatch exp port=%0d last=%0b empty=%0b oog=%0b",
                            " got port=%0d last=%0b empty=%0b oog=%0b"},
                           $realtime, want.hop_port, want.last_hop, want.route_empty,
                           want.node_out_of_grid, rsp_hop_port, rsp_last_hop,
                           rsp_route_empty, rsp_node_out_of_grid);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: count cycles with no transaction on any port
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_psel) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

endmodule

// ===== torus_source_route_generator.f =====
rtl/tsr_pkg.sv
rtl/tsr_front.sv
rtl/tsr_queue.sv
rtl/tsr_back.sv
rtl/torus_source_route_generator.sv
tb/tb_top.sv
